// ===== src/bei_pkg.sv =====
// Shared types, codes and sizes for the breakpoint envelope interpolator.
// No dependencies; imported by bei_div, the top level and the testbench.
`default_nettype none

package bei_pkg;

	// Field widths of one input beat and one result beat
	localparam int FUNC_W   = 2;
	localparam int TIME_W   = 32;
	localparam int LEVEL_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Table depth default
	localparam int MAX_POINTS_DEF = 256;

	// One table entry holds a time and a level
	localparam int ENTRY_W = TIME_W + LEVEL_W;

	// Product of two magnitudes and the iterative divider
	localparam int PROD_W    = 2 * TIME_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_ORDER = 2'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd3;

endpackage

`default_nettype wire

// ===== src/bei_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing; holds the breakpoint table.
`default_nettype none

module bei_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/bei_div.sv =====
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on bei_pkg for widths and step count.
`default_nettype none

module bei_div
	import bei_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] dividend,
	input  wire logic [TIME_W-1:0] divisor,
	output logic                   done,
	output logic      [PROD_W-1:0] quotient
);

	logic [TIME_W-1:0]    rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [TIME_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// trial subtraction of one step
	logic [TIME_W:0] trial;
	logic [TIME_W:0] diff;
	logic            fits;

	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// shift loop; quo_q starts as the dividend and fills with quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/breakpoint_envelope_interpolator.sv =====
// Breakpoint envelope interpolator: top level with sequencer, table RAM and divider.
// Depends on bei_pkg, bei_ram and bei_div.
//
// Input channel (in_valid / in_stall) carries func, when and level. func selects
// clear, append or query. Output channel (out_valid / out_stall) returns one
// beat per input beat: level_out, status and count.
// One beat is in work at a time, passing through the states listed below;
// in_stall is high while a beat is in work.
// States from accept to result register:
//   clear, unused code, full-table or first append: ST_DONE
//   any other append: ST_APP_RD, ST_APP_CHK, ST_DONE (reads the last stored time first)
//   query on empty table: ST_DONE
//   query: ST_SCAN, ST_CALC, ST_MUL, ST_DIV, ST_FIN, ST_DONE;
//   the scan reads one table entry a cycle through the RAM read port up to the
//   right point found, and the 64-step divider works in ST_DIV. A zero-width segment
//   goes ST_SCAN, ST_CALC, ST_DONE, a time past the last point ST_SCAN, ST_DONE.
// A finished result sits in the output register; the next beat is taken while it
// waits. If the receiver stalls, the following result holds until it drains.
// Reset empties the table (count 0) and drops any result in flight; the RAM
// contents are not cleared, as entries at or above the count are never read.
`default_nettype none

module breakpoint_envelope_interpolator
	import bei_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic        [FUNC_W-1:0]   func,
	input  wire logic        [TIME_W-1:0]   when,
	input  wire logic signed [LEVEL_W-1:0]  level,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed      [LEVEL_W-1:0]  level_out,
	output logic             [STATUS_W-1:0] status,
	output logic             [COUNT_W-1:0]  count
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int SW = LEVEL_W + 4;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_APP_RD  = 9'b000000010,
		ST_APP_CHK = 9'b000000100,
		ST_SCAN    = 9'b000001000,
		ST_CALC    = 9'b000010000,
		ST_MUL     = 9'b000100000,
		ST_DIV     = 9'b001000000,
		ST_FIN     = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	// latched input beat and table fill
	logic [TIME_W-1:0]  when_q;
	logic [LEVEL_W-1:0] level_q;
	logic [CW-1:0]      count_q;

	// scan pointers
	logic [CW-1:0] addr_q;
	logic [CW-1:0] k_s1;
	logic          rd_vld_s1;

	// segment endpoints and arithmetic operands
	logic [TIME_W-1:0]  lt_q, rt_q;
	logic [LEVEL_W-1:0] lv_q, rv_q;
	logic [TIME_W-1:0]  mag_v_q, mag_t_q, width_q;
	logic               neg_q;

	// pending result and output register
	logic [LEVEL_W-1:0]  res_level_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_out_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       count_out_q;

	// RAM ports
	logic               rd_en, wr_en;
	logic [IW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] wr_data, rd_data;
	logic [TIME_W-1:0]  rd_time;
	logic [LEVEL_W-1:0] rd_level;
	logic [CW-1:0]      cnt_m1;
	logic               late;

	assign rd_time  = rd_data[ENTRY_W-1:LEVEL_W];
	assign rd_level = rd_data[LEVEL_W-1:0];
	assign cnt_m1   = count_q - 1'b1;
	assign late     = when_q < rd_time;

	// table memory access
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_data = {when_q, level_q};
		if (state_q == ST_APP_RD) begin
			rd_en   = 1'b1;
			rd_addr = cnt_m1[IW-1:0];
		end else if (state_q == ST_SCAN) begin
			rd_en = addr_q < count_q;
		end
		if (state_q == ST_IDLE && in_valid && func == FN_APPEND && count_q == '0) begin
			wr_en   = 1'b1;
			wr_data = {when, level};
		end else if (state_q == ST_APP_CHK && !late) begin
			wr_en = 1'b1;
		end
	end

	bei_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// segment setup: width, value delta and time offset as sign and magnitude
	logic [TIME_W-1:0]  width_c;
	logic [LEVEL_W:0]   dv_c, dv_mag_c;
	logic               neg_t_c;
	logic [TIME_W-1:0]  mag_t_c;

	assign width_c  = rt_q - lt_q;
	assign dv_c     = {rv_q[LEVEL_W-1], rv_q} - {lv_q[LEVEL_W-1], lv_q};
	assign dv_mag_c = dv_c[LEVEL_W] ? (~dv_c + 1'b1) : dv_c;
	assign neg_t_c  = when_q < lt_q;
	assign mag_t_c  = neg_t_c ? (lt_q - when_q) : (when_q - lt_q);

	// divider fed straight from the multiplier; it registers the product
	logic              div_start, div_done;
	logic [PROD_W-1:0] div_quo;

	assign div_start = state_q == ST_MUL;

	bei_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_v_q * mag_t_q),
		.divisor  (width_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// add quotient to the left level and saturate
	logic          big_c, neg_c;
	logic [SW-1:0] lv_x, q_x, sum_c;
	logic [LEVEL_W-1:0] sat_c;

	assign big_c = div_quo > {{(PROD_W-TIME_W-2){1'b0}}, 2'b10, {TIME_W{1'b0}}};
	assign neg_c = neg_q && (div_quo != '0);
	assign lv_x  = {{(SW-LEVEL_W){lv_q[LEVEL_W-1]}}, lv_q};
	assign q_x   = {{(SW-LEVEL_W-2){1'b0}}, div_quo[LEVEL_W+1:0]};
	assign sum_c = neg_c ? (lv_x - q_x) : (lv_x + q_x);

	always_comb begin
		if (big_c) begin
			sat_c = neg_c ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
		end else if (sum_c[SW-1:LEVEL_W-1] != {(SW-LEVEL_W+1){sum_c[SW-1]}}) begin
			sat_c = sum_c[SW-1] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
		end else begin
			sat_c = sum_c[LEVEL_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			when_q       <= '0;
			level_q      <= '0;
			count_q      <= '0;
			addr_q       <= '0;
			k_s1         <= '0;
			rd_vld_s1    <= 1'b0;
			lt_q         <= '0;
			rt_q         <= '0;
			lv_q         <= '0;
			rv_q         <= '0;
			mag_v_q      <= '0;
			mag_t_q      <= '0;
			width_q      <= '0;
			neg_q        <= 1'b0;
			res_level_q  <= '0;
			res_status_q <= STS_OK;
			out_valid_q  <= 1'b0;
			level_out_q  <= '0;
			status_q     <= STS_OK;
			count_out_q  <= '0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						when_q       <= when;
						level_q      <= level;
						res_level_q  <= '0;
						res_status_q <= STS_OK;
						addr_q       <= '0;
						state_q      <= ST_DONE;
						unique case (func)
							FN_CLEAR: begin
								count_q <= '0;
							end
							FN_APPEND: begin
								if (count_q >= CW'(MAX_POINTS)) begin
									res_status_q <= STS_FULL;
								end else if (count_q == '0) begin
									count_q <= count_q + 1'b1;
								end else begin
									state_q <= ST_APP_RD;
								end
							end
							FN_QUERY: begin
								if (count_q == '0) begin
									res_status_q <= STS_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_APP_RD: begin
					state_q <= ST_APP_CHK;
				end
				ST_APP_CHK: begin
					if (late) begin
						res_status_q <= STS_ORDER;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (rd_en) begin
						addr_q <= addr_q + 1'b1;
					end
					rd_vld_s1 <= rd_en;
					k_s1      <= addr_q;
					if (rd_vld_s1) begin
						if (k_s1 != '0 && !(when_q > rd_time)) begin
							rt_q      <= rd_time;
							rv_q      <= rd_level;
							rd_vld_s1 <= 1'b0;
							state_q   <= ST_CALC;
						end else if (k_s1 == cnt_m1) begin
							res_level_q <= rd_level;
							rd_vld_s1   <= 1'b0;
							state_q     <= ST_DONE;
						end else begin
							lt_q <= rd_time;
							lv_q <= rd_level;
						end
					end
				end
				ST_CALC: begin
					mag_v_q <= dv_mag_c[LEVEL_W-1:0];
					mag_t_q <= mag_t_c;
					width_q <= width_c;
					neg_q   <= dv_c[LEVEL_W] ^ neg_t_c;
					if (width_c == '0) begin
						res_level_q <= rv_q;
						state_q     <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					res_level_q <= sat_c;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						level_out_q <= res_level_q;
						status_q    <= res_status_q;
						count_out_q <= count_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// outputs
	logic [CW+COUNT_W-1:0] count_wide;

	assign count_wide = {{COUNT_W{1'b0}}, count_out_q};
	assign in_stall   = state_q != ST_IDLE;
	assign out_valid  = out_valid_q;
	assign level_out  = level_out_q;
	assign status     = status_q;
	assign count      = count_wide[COUNT_W-1:0];

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("table count above depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q < CW'(MAX_POINTS))
		else $error("table write with full table");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && state_q == ST_SCAN) |-> addr_q < count_q)
		else $error("scan read beyond stored points");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat not from done state");

endmodule

`default_nettype wire

// ===== tb/breakpoint_envelope_interpolator_tb.sv =====
// Self-checking testbench for the breakpoint envelope interpolator.
// Needs bei_pkg and breakpoint_envelope_interpolator; predicts every result beat in-line.
`default_nettype none

module breakpoint_envelope_interpolator_tb
	import bei_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_AT      = 400;   // accepted beats before the long receiver hold
	localparam int HOLD_CYCLES  = 600;
	localparam int CALM_FROM    = 700;   // window of accepted beats with no idling
	localparam int CALM_TO      = 900;
	localparam int TAIL_CYCLES  = 400;   // idle time after the last result beat

	// Selector with no operation behind it
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam longint LEVEL_MAX = 64'sd2147483647;
	localparam longint LEVEL_MIN = -64'sd2147483648;

	typedef struct {
		logic [FUNC_W-1:0]         func;
		logic [TIME_W-1:0]         when;
		logic signed [LEVEL_W-1:0] level;
		bit                        drain_first;
	} op_beat_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level_out;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
	} env_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [TIME_W-1:0] when = '0;
	logic signed [LEVEL_W-1:0] level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [LEVEL_W-1:0] level_out;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] count;

	breakpoint_envelope_interpolator #(
		.MAX_POINTS(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.when(when),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level_out(level_out),
		.status(status),
		.count(count)
	);

	always #10 clk = ~clk;

	op_beat_t    pending_ops[$];
	env_result_t expected_results[$];
	int          stimulus_items = 0;
	int          accepted_beats = 0;
	int          mismatches = 0;
	logic        in_taken = 1'b0;

	// Predictor copy of the breakpoint table
	logic [TIME_W-1:0]         env_times[TABLE_DEPTH];
	logic signed [LEVEL_W-1:0] env_levels[TABLE_DEPTH];
	int                        env_count = 0;

	wire calm = accepted_beats >= CALM_FROM && accepted_beats < CALM_TO;

	// Envelope level at time 'at'; table holds at least one point
	function automatic logic signed [LEVEL_W-1:0] envelope_at(logic [TIME_W-1:0] at);
		int seg;
		logic [TIME_W-1:0] lt, rt, span, dt;
		longint lv, rv, dv, r;
		logic [63:0] mag_v, mag_t, q;
		bit neg_v, neg_t, neg;
		seg = 1;
		while (seg < env_count && at > env_times[seg])
			seg++;
		if (seg >= env_count)
			return env_levels[env_count-1];
		lt = env_times[seg-1];
		rt = env_times[seg];
		lv = env_levels[seg-1];
		rv = env_levels[seg];
		span = rt - lt;
		if (span == '0)
			return env_levels[seg];
		dv = rv - lv;
		neg_v = dv < 0;
		mag_v = neg_v ? -dv : dv;
		neg_t = at < lt;
		dt = neg_t ? lt - at : at - lt;
		mag_t = {32'b0, dt};
		q = (mag_v * mag_t) / {32'b0, span};
		neg = (neg_v != neg_t) && q != 0;
		// Far beyond range: saturate without forming the sum
		if (q > 64'h2_0000_0000) begin
			r = neg ? LEVEL_MIN : LEVEL_MAX;
		end else begin
			r = neg ? lv - longint'(q) : lv + longint'(q);
			if (r > LEVEL_MAX) r = LEVEL_MAX;
			if (r < LEVEL_MIN) r = LEVEL_MIN;
		end
		return r[LEVEL_W-1:0];
	endfunction

	// Apply one operation to the table copy and return its result beat
	function automatic env_result_t apply_op(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] at,
			logic signed [LEVEL_W-1:0] lvl);
		env_result_t res;
		res.level_out = '0;
		res.status = STS_OK;
		case (f)
			FN_CLEAR: begin
				env_count = 0;
			end
			FN_APPEND: begin
				if (env_count >= TABLE_DEPTH) begin
					res.status = STS_FULL;
				end else if (env_count > 0 && at < env_times[env_count-1]) begin
					res.status = STS_ORDER;
				end else begin
					env_times[env_count] = at;
					env_levels[env_count] = lvl;
					env_count++;
				end
			end
			FN_QUERY: begin
				if (env_count == 0)
					res.status = STS_EMPTY;
				else
					res.level_out = envelope_at(at);
			end
			default: ;
		endcase
		res.count = env_count[COUNT_W-1:0];
		return res;
	endfunction

	task automatic push_op(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] at,
			logic [LEVEL_W-1:0] lvl, bit drain = 1'b0);
		op_beat_t b;
		b.func = f;
		b.when = at;
		b.level = lvl;
		b.drain_first = drain;
		pending_ops.push_back(b);
		if (f != FN_UNUSED)
			stimulus_items++;
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level(int mode);
		logic [LEVEL_W-1:0] lvl;
		case (mode)
			0: lvl = $urandom;
			1: lvl = $urandom_range(32'h40000) - 32'h20000;
			default: begin
				case ($urandom_range(4))
					0: lvl = 32'h7FFF_FFFF;
					1: lvl = 32'h8000_0000;
					2: lvl = 32'h0;
					3: lvl = 32'hFFFF_FFFF;
					default: lvl = $urandom;
				endcase
			end
		endcase
		return lvl;
	endfunction

	// One envelope: clear, non-decreasing appends with occasional out-of-order ones, then queries
	task automatic add_envelope(bit fill_table, bit drain);
		logic [TIME_W-1:0] knots[$];
		logic [TIME_W:0] t;
		logic [TIME_W-1:0] step, qt;
		int n, nq, time_mode, lvl_mode, idx;
		push_op(FN_CLEAR, $urandom, $urandom, drain);
		n = fill_table ? TABLE_DEPTH + $urandom_range(3, 1) : $urandom_range(9);
		time_mode = $urandom_range(2);
		lvl_mode = $urandom_range(2);
		t = {1'b0, (time_mode == 0) ? $urandom_range(50) : $urandom};
		for (int k = 0; k < n; k++) begin
			// Occasional out-of-order append
			if (knots.size() > 0 && knots[$] != 0 && $urandom_range(15) == 0)
				push_op(FN_APPEND, $urandom_range(knots[$] - 1, 0), $urandom);
			push_op(FN_APPEND, t[TIME_W-1:0], pick_level(lvl_mode));
			knots.push_back(t[TIME_W-1:0]);
			case (time_mode)
				0: step = $urandom_range(20);
				1: step = $urandom_range(1000);
				default: step = $urandom >> $urandom_range(31);
			endcase
			if ($urandom_range(7) == 0)
				step = '0;
			t = t + step;
			if (t[TIME_W])
				t = {1'b0, {TIME_W{1'b1}}};
		end
		nq = $urandom_range(6, 1);
		for (int k = 0; k < nq; k++) begin
			if (knots.size() == 0) begin
				qt = $urandom;
			end else begin
				idx = $urandom_range(knots.size() - 1);
				case ($urandom_range(4))
					0: qt = knots[idx];
					1: qt = knots[idx] + $urandom_range(8) - 4;
					2: qt = $urandom;
					3: qt = knots[0] - ($urandom >> $urandom_range(31));
					default: qt = knots[$] + ($urandom >> $urandom_range(31));
				endcase
			end
			push_op(FN_QUERY, qt, $urandom);
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		int target, session;
		// Directed: empty table, unused code, single point, order error
		push_op(FN_QUERY, 32'h1234_5678, 32'h0);
		push_op(FN_UNUSED, 32'h0, 32'h0);
		push_op(FN_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		push_op(FN_QUERY, 32'h0, 32'h0);
		push_op(FN_APPEND, 32'h0, 32'h0);
		// Zero-width first segment, interior, past the last point
		push_op(FN_CLEAR, 32'h0, 32'h0);
		push_op(FN_APPEND, 32'd500, 32'h0003_0000);
		push_op(FN_APPEND, 32'd500, 32'h8000_0000);
		push_op(FN_QUERY, 32'd400, 32'h0);
		push_op(FN_APPEND, 32'd1000, 32'h7FFF_FFFF);
		push_op(FN_QUERY, 32'd750, 32'h0);
		push_op(FN_QUERY, 32'hFFFF_FFFF, 32'h0);
		// Steep first segment: extrapolation saturates low
		push_op(FN_CLEAR, 32'h0, 32'h0);
		push_op(FN_APPEND, 32'd1000, 32'h0001_0000);
		push_op(FN_APPEND, 32'd1010, 32'h7FFF_FFFF);
		push_op(FN_QUERY, 32'd0, 32'h0);
		push_op(FN_QUERY, 32'd1003, 32'h0);
		push_op(FN_APPEND, 32'h8000_0000, 32'hFFFF_0000);
		push_op(FN_QUERY, 32'h4000_0000, 32'h0);
		push_op(FN_UNUSED, 32'hFFFF_FFFF, 32'h8000_0000);
		// Descending first segment: extrapolation saturates high
		push_op(FN_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(FN_APPEND, 32'd10, 32'h7FFF_FFFF);
		push_op(FN_APPEND, 32'd11, 32'h8000_0000);
		push_op(FN_QUERY, 32'd0, 32'h0);
		push_op(FN_QUERY, 32'd11, 32'h0);

		// Random envelopes with some noise between them
		target = stimulus_items + RANDOM_ITEMS;
		session = 0;
		while (stimulus_items < target) begin
			add_envelope(session == 3 || $urandom_range(49) == 0, session % 25 == 12);
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(3, 1))
					push_op(FUNC_W'($urandom_range(3)), $urandom, $urandom);
			session++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Driver: present the next beat once the current one is taken
	always @(negedge clk) begin : drive
		op_beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled beat holds
		end else if (pending_ops.size() != 0 && !(!calm && $urandom_range(99) < 9)
				&& !(pending_ops[0].drain_first && expected_results.size() != 0)) begin
			b = pending_ops.pop_front();
			in_valid <= 1'b1;
			func <= b.func;
			when <= b.when;
			level <= b.level;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver stall: random, plus one long hold to back the block up
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_beats >= HOLD_AT) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 9;
		end
	end

	// Monitor: check result beats, then predict for the accepted input beat
	always @(posedge clk) begin : observe
		env_result_t got, want;
		in_taken <= arst_n && in_valid && in_stall === 1'b0;
		if (arst_n) begin
			if (out_valid === 1'b1 && !out_stall) begin
				got = {level_out, status, count};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat: level %h status %0d count %0d",
						$time, got.level_out, got.status, got.count);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
							$time, want.level_out, want.status, want.count,
							got.level_out, got.status, got.count);
						mismatches++;
					end
				end
			end
			if (in_valid && in_stall === 1'b0) begin
				expected_results.push_back(apply_op(func, when, level));
				accepted_beats++;
			end
		end
	end

endmodule

`default_nettype wire

// ===== breakpoint_envelope_interpolator.f =====
src/bei_pkg.sv
src/bei_ram.sv
src/bei_div.sv
src/breakpoint_envelope_interpolator.sv
tb/breakpoint_envelope_interpolator_tb.sv
